FILE: rtl/pah_pkg.sv
// Shared types and constants for the heading PID controller.
`default_nettype none

package pah_pkg;

    // Default fractional width of the internal radian and drive arithmetic.
    localparam int FRAC_BITS_DEF = 16;

    // Fixed field widths.
    localparam int ANGLE_W  = 16;   // Q10.6 degree inputs
    localparam int ANGLE_FRAC = 6;
    localparam int GAIN_W   = 32;   // Q16.16 gains
    localparam int GAIN_FRAC = 16;
    localparam int LIM_W    = 16;   // Q2.14 limits and drive
    localparam int LIM_FRAC = 14;
    localparam int ERR_W    = 32;   // error, previous error, correction
    localparam int SUM_W    = 48;   // error integral
    localparam int MUL_A_W  = 33;   // shared multiplier, first operand
    localparam int MUL_B_W  = 32;   // shared multiplier, second operand
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int ACC_W    = 66;   // P + I + D accumulator
    localparam int WIDE_W   = ACC_W + 1;

    // Degrees to radians, Q30: round(3.1416 / 180 * 2^30).
    localparam int K_FRAC = 30;
    localparam logic signed [MUL_B_W-1:0] DEG2RAD_Q30 = 32'sd18740374;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN   = 3'd0,
        CFG_INT_GAIN    = 3'd1,
        CFG_DERIV_GAIN  = 3'd2,
        CFG_UPPER_LIMIT = 3'd3,
        CFG_LOWER_LIMIT = 3'd4,
        CFG_WINDUP_GAIN = 3'd5
    } t_cfg_idx;

    localparam logic signed [LIM_W-1:0] UPPER_RESET = 16'sd8192;
    localparam logic signed [LIM_W-1:0] LOWER_RESET = -16'sd8192;

    // Input command codes.
    localparam logic CMD_RUN   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Sequencer steps.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CONV_REF,
        ST_CONV_MEAS,
        ST_ERROR,
        ST_STATE,
        ST_P,
        ST_I_HI,
        ST_I_LO,
        ST_D,
        ST_CLAMP,
        ST_GAP,
        ST_WMUL,
        ST_WIND,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/pid_antiwindup_heading.sv
// Heading PID controller with back-calculation anti-windup on one shared multiplier.
//
// Usage: an input word on s_axis carries the reference heading (tdata bits
// 15:0) and the measured heading (bits 31:16), both Q10.6 degrees, and the
// command in tuser (0 runs one control step, 1 clears the controller state).
// Each word yields exactly one result word on m_axis: the clamped drive in
// Q2.14 (tdata) and the clamp flag (tuser).
// A control step passes through thirteen sequencer steps from acceptance to the
// result in the output register, seven of which are passes through the single
// 33 x 32 multiplier, and no new word is taken until the step is done. A clear
// command goes straight to the last step (ST_DONE) and from there to the output
// register. s_axis_tready is high only while the sequencer is idle.
// The result is held in an output register, so a new word is accepted while
// the previous result waits; if the receiver stalls, the finished step waits
// in its last state until the output register is free.
// Synchronous reset empties the output register, zeroes the integral,
// previous error and anti-windup term, and loads the register defaults
// (gains zero, limits +0.5 and -0.5). Gains and limits are written through the
// configuration port; the user must write them only while the block is idle, which the block itself does not enforce.
`default_nettype none

module pid_antiwindup_heading #(
    parameter int FRAC_BITS = pah_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration writes
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [pah_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [pah_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // input stream
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [2*pah_pkg::ANGLE_W-1:0]       s_axis_tdata,  // reference_deg, measured_deg
    input  wire logic                                s_axis_tuser,  // command
    // output stream
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [pah_pkg::LIM_W-1:0]                m_axis_tdata,  // drive
    output logic                                     m_axis_tuser   // clamped
);

    localparam int ERR_W   = pah_pkg::ERR_W;
    localparam int SUM_W   = pah_pkg::SUM_W;
    localparam int ACC_W   = pah_pkg::ACC_W;
    localparam int WIDE_W  = pah_pkg::WIDE_W;
    localparam int PROD_W  = pah_pkg::PROD_W;
    localparam int MUL_A_W = pah_pkg::MUL_A_W;
    localparam int MUL_B_W = pah_pkg::MUL_B_W;
    localparam int GAIN_W  = pah_pkg::GAIN_W;
    localparam int GF      = pah_pkg::GAIN_FRAC;
    localparam int LIM_W   = pah_pkg::LIM_W;
    localparam int ANGLE_W = pah_pkg::ANGLE_W;

    // Degree product is Q(6 + 30); shift it down to Q(FRAC_BITS) with rounding.
    localparam int RAD_SHIFT = pah_pkg::ANGLE_FRAC + pah_pkg::K_FRAC - FRAC_BITS;
    localparam int RAD_ROUND = 1 << (RAD_SHIFT - 1);
    // Scaling between Q2.14 and Q(FRAC_BITS).
    localparam int LIM_SHL = (FRAC_BITS >= pah_pkg::LIM_FRAC) ?
                             FRAC_BITS - pah_pkg::LIM_FRAC : 0;
    localparam int LIM_SHR = (FRAC_BITS >= pah_pkg::LIM_FRAC) ?
                             0 : pah_pkg::LIM_FRAC - FRAC_BITS;

    // Saturate a wide signed value to the 32-bit signed range.
    function automatic logic signed [ERR_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
        logic signed [ERR_W-1:0] res;
        if (x[WIDE_W-1] && !(&x[WIDE_W-1:ERR_W-1])) begin
            res = {1'b1, {(ERR_W-1){1'b0}}};
        end else if (!x[WIDE_W-1] && (|x[WIDE_W-1:ERR_W-1])) begin
            res = {1'b0, {(ERR_W-1){1'b1}}};
        end else begin
            res = $signed(x[ERR_W-1:0]);
        end
        return res;
    endfunction

    // Saturate the integral update to the 48-bit signed range.
    function automatic logic signed [SUM_W-1:0] sat48(input logic signed [SUM_W+1:0] x);
        logic signed [SUM_W-1:0] res;
        if (x[SUM_W+1] && !(&x[SUM_W+1:SUM_W-1])) begin
            res = {1'b1, {(SUM_W-1){1'b0}}};
        end else if (!x[SUM_W+1] && (|x[SUM_W+1:SUM_W-1])) begin
            res = {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            res = $signed(x[SUM_W-1:0]);
        end
        return res;
    endfunction

    pah_pkg::t_state r_state, n_state;

    // Configuration registers.
    logic signed [GAIN_W-1:0] r_kp, r_ki, r_kd, r_kw;
    logic signed [LIM_W-1:0]  r_upper, r_lower;

    // Controller state.
    logic signed [ERR_W-1:0]  r_prev, r_wc;
    logic signed [SUM_W-1:0]  r_sum;

    // Working registers.
    logic signed [ANGLE_W-1:0] r_ref, r_meas;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ERR_W-1:0]   r_rad, r_err, r_diff, r_gap;
    logic signed [ACC_W-1:0]   r_acc, r_outf;
    logic [LIM_W-1:0]          r_drive;
    logic                      r_clamped;

    // Output register.
    logic                      r_m_valid;
    logic [LIM_W-1:0]          r_m_drive;
    logic                      r_m_clamped;

    logic                      in_accept;
    logic                      load_out;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [PROD_W-1:0]  rad_full;
    logic signed [ERR_W-1:0]   rad_now;
    logic signed [PROD_W-1:0]  prod_q16;
    logic signed [ERR_W:0]     err_wide, diff_wide;
    logic signed [SUM_W+1:0]   sum_wide;
    logic signed [ACC_W-1:0]   upper_f, lower_f, q14_wide;
    logic signed [WIDE_W-1:0]  gap_wide;

    assign s_axis_tready = (r_state == pah_pkg::ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_drive;
    assign m_axis_tuser  = r_m_clamped;

    // Sequencer: next step and output register load.
    always_comb begin
        n_state  = r_state;
        load_out = 1'b0;
        unique case (r_state)
            pah_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_state = (s_axis_tuser == pah_pkg::CMD_CLEAR) ?
                              pah_pkg::ST_DONE : pah_pkg::ST_CONV_REF;
                end
            end
            pah_pkg::ST_CONV_REF:  n_state = pah_pkg::ST_CONV_MEAS;
            pah_pkg::ST_CONV_MEAS: n_state = pah_pkg::ST_ERROR;
            pah_pkg::ST_ERROR:     n_state = pah_pkg::ST_STATE;
            pah_pkg::ST_STATE:     n_state = pah_pkg::ST_P;
            pah_pkg::ST_P:         n_state = pah_pkg::ST_I_HI;
            pah_pkg::ST_I_HI:      n_state = pah_pkg::ST_I_LO;
            pah_pkg::ST_I_LO:      n_state = pah_pkg::ST_D;
            pah_pkg::ST_D:         n_state = pah_pkg::ST_CLAMP;
            pah_pkg::ST_CLAMP:     n_state = pah_pkg::ST_GAP;
            pah_pkg::ST_GAP:       n_state = pah_pkg::ST_WMUL;
            pah_pkg::ST_WMUL:      n_state = pah_pkg::ST_WIND;
            pah_pkg::ST_WIND:      n_state = pah_pkg::ST_DONE;
            pah_pkg::ST_DONE: begin
                if (!r_m_valid || m_axis_tready) begin
                    load_out = 1'b1;
                    n_state  = pah_pkg::ST_IDLE;
                end
            end
            default: n_state = pah_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pah_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            pah_pkg::ST_CONV_REF: begin
                mul_a = MUL_A_W'(r_ref);
                mul_b = pah_pkg::DEG2RAD_Q30;
            end
            pah_pkg::ST_CONV_MEAS: begin
                mul_a = MUL_A_W'(r_meas);
                mul_b = pah_pkg::DEG2RAD_Q30;
            end
            pah_pkg::ST_STATE: begin
                mul_a = MUL_A_W'(r_err);
                mul_b = r_kp;
            end
            pah_pkg::ST_P: begin
                // Upper part of the integral, floor(sum / 2^16).
                mul_a = MUL_A_W'($signed(r_sum[SUM_W-1:GF]));
                mul_b = r_ki;
            end
            pah_pkg::ST_I_HI: begin
                // Lower 16 bits of the integral, taken as unsigned.
                mul_a = $signed({{(MUL_A_W-GF){1'b0}}, r_sum[GF-1:0]});
                mul_b = r_ki;
            end
            pah_pkg::ST_I_LO: begin
                mul_a = MUL_A_W'(r_diff);
                mul_b = r_kd;
            end
            pah_pkg::ST_WMUL: begin
                mul_a = MUL_A_W'(r_gap);
                mul_b = r_kw;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Arithmetic on the registered product and the state.
    assign rad_full  = (r_prod + PROD_W'(RAD_ROUND)) >>> RAD_SHIFT;
    assign rad_now   = $signed(rad_full[ERR_W-1:0]);
    assign prod_q16  = r_prod >>> GF;
    assign err_wide  = (ERR_W+1)'(r_rad) - (ERR_W+1)'(rad_now);
    assign diff_wide = (ERR_W+1)'(r_err) - (ERR_W+1)'(r_prev);
    assign sum_wide  = (SUM_W+2)'(r_sum) + (SUM_W+2)'(r_err) + (SUM_W+2)'(r_wc);
    assign upper_f   = (ACC_W'(r_upper) <<< LIM_SHL) >>> LIM_SHR;
    assign lower_f   = (ACC_W'(r_lower) <<< LIM_SHL) >>> LIM_SHR;
    assign q14_wide  = (r_acc >>> LIM_SHL) <<< LIM_SHR;
    assign gap_wide  = WIDE_W'(r_outf) - WIDE_W'(r_acc);

    // Configuration registers and controller state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp    <= '0;
            r_ki    <= '0;
            r_kd    <= '0;
            r_kw    <= '0;
            r_upper <= pah_pkg::UPPER_RESET;
            r_lower <= pah_pkg::LOWER_RESET;
            r_prev  <= '0;
            r_sum   <= '0;
            r_wc    <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    pah_pkg::CFG_PROP_GAIN:   r_kp    <= $signed(i_cfg_data);
                    pah_pkg::CFG_INT_GAIN:    r_ki    <= $signed(i_cfg_data);
                    pah_pkg::CFG_DERIV_GAIN:  r_kd    <= $signed(i_cfg_data);
                    pah_pkg::CFG_UPPER_LIMIT: r_upper <= $signed(i_cfg_data[LIM_W-1:0]);
                    pah_pkg::CFG_LOWER_LIMIT: r_lower <= $signed(i_cfg_data[LIM_W-1:0]);
                    pah_pkg::CFG_WINDUP_GAIN: r_kw    <= $signed(i_cfg_data);
                    default: ;
                endcase
            end
            if (in_accept && (s_axis_tuser == pah_pkg::CMD_CLEAR)) begin
                r_prev <= '0;
                r_sum  <= '0;
                r_wc   <= '0;
            end else if (r_state == pah_pkg::ST_STATE) begin
                r_sum  <= sat48(sum_wide);
                r_prev <= r_err;
            end else if (r_state == pah_pkg::ST_WIND) begin
                r_wc   <= sat32(WIDE_W'(prod_q16));
            end
        end
    end

    // Datapath working registers.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        case (r_state)
            pah_pkg::ST_IDLE: begin
                r_ref     <= $signed(s_axis_tdata[ANGLE_W-1:0]);
                r_meas    <= $signed(s_axis_tdata[2*ANGLE_W-1:ANGLE_W]);
                r_drive   <= '0;
                r_clamped <= 1'b0;
            end
            pah_pkg::ST_CONV_MEAS: r_rad  <= rad_now;
            pah_pkg::ST_ERROR:     r_err  <= sat32(WIDE_W'(err_wide));
            pah_pkg::ST_STATE:     r_diff <= sat32(WIDE_W'(diff_wide));
            pah_pkg::ST_P:         r_acc  <= ACC_W'(prod_q16);
            pah_pkg::ST_I_HI:      r_acc  <= r_acc + ACC_W'(r_prod);
            pah_pkg::ST_I_LO:      r_acc  <= r_acc + ACC_W'(prod_q16);
            pah_pkg::ST_D:         r_acc  <= r_acc + ACC_W'(prod_q16);
            pah_pkg::ST_CLAMP: begin
                // Upper limit is tested first, so a value past both crossed limits gives the upper one.
                if (r_acc > upper_f) begin
                    r_outf    <= upper_f;
                    r_drive   <= r_upper;
                    r_clamped <= 1'b1;
                end else if (r_acc < lower_f) begin
                    r_outf    <= lower_f;
                    r_drive   <= r_lower;
                    r_clamped <= 1'b1;
                end else begin
                    r_outf    <= r_acc;
                    r_drive   <= q14_wide[LIM_W-1:0];
                    r_clamped <= 1'b0;
                end
            end
            pah_pkg::ST_GAP:       r_gap  <= sat32(gap_wide);
            default: ;
        endcase
    end

    // Output register: holds a result until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (load_out) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_m_drive   <= r_drive;
            r_m_clamped <= r_clamped;
        end
    end

endmodule

`default_nettype wire
